FILE: rtl/core/node_store_nearest_search_assert.svh
// Assertion macros used by the point store controller.
// Include with the bare file name; no other dependencies.
`ifndef NODE_STORE_NEAREST_SEARCH_ASSERT_SVH
`define NODE_STORE_NEAREST_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NSNS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NSNS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/nsns_pkg.sv
// Shared types and constants for the point store with nearest-point search.
// Used by the controller, the datapath and the top level; no dependencies.
package nsns_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF = 16;

  localparam int unsigned IDENT_W = 16;
  localparam int unsigned TOL_W   = 34;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 64;

  // Register index taken from paddr[3] (one 8-byte slot per register).
  localparam logic TOL_REG_IDX = 1'b0;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic rd_en;     // read one stored point
    logic rd_first;  // the read is entry 0
    logic rd_last;   // the read is the last stored entry
    logic flush;     // drop everything in the compare pipeline
    logic out_load;  // capture the result into the output register
  } cmd_t;

  typedef struct packed {
    logic hit;        // compare stage found a point within tolerance
    logic last_done;  // compare stage handled the last stored point
    logic out_free;   // output register can take a result this cycle
  } status_t;

endpackage

FILE: rtl/core/nsns_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
module nsns_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/nsns_ctrl.sv
// Controller: accepts beats, sequences the scan over stored points, loads results.
// Depends on nsns_pkg and node_store_nearest_search_assert.svh.
`include "node_store_nearest_search_assert.svh"

module nsns_ctrl #(
  parameter int unsigned MAX_POINTS = nsns_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              in_operation_i,
  input  logic [$clog2(MAX_POINTS+1)-1:0]   count_i,
  input  nsns_pkg::status_t                 status_i,
  output nsns_pkg::cmd_t                    cmd_o,
  output logic [$clog2(MAX_POINTS+1)-1:0]   rd_addr_o
);

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  nsns_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic             accept;
  logic             scan_end;

  assign accept   = (state_q == nsns_pkg::ST_IDLE) && in_valid_i;
  assign scan_end = status_i.hit || status_i.last_done;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nsns_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_operation_i == nsns_pkg::OP_QUERY && count_i != '0) begin
            state_d = nsns_pkg::ST_SCAN;
          end else begin
            state_d = nsns_pkg::ST_RESULT;
          end
        end
      end
      nsns_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = nsns_pkg::ST_RESULT;
        end
      end
      nsns_pkg::ST_RESULT: begin
        if (status_i.out_free) begin
          state_d = nsns_pkg::ST_IDLE;
        end
      end
      default: state_d = nsns_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    issue_d    = issue_q;
    case (state_q)
      nsns_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        issue_d      = '0;
      end
      nsns_pkg::ST_SCAN: begin
        cmd_o.rd_en    = issue_q < count_i;
        cmd_o.rd_first = issue_q == '0;
        cmd_o.rd_last  = (issue_q + CNT_W'(1)) == count_i;
        cmd_o.flush    = scan_end;
        if (cmd_o.rd_en) begin
          issue_d = issue_q + CNT_W'(1);
        end
      end
      nsns_pkg::ST_RESULT: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign rd_addr_o = issue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nsns_pkg::ST_IDLE;
      issue_q <= '0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
    end
  end

  `NSNS_ASSERT_IMP(a_issue_bound, clk_i, rst_ni, state_q == nsns_pkg::ST_SCAN, issue_q <= count_i, "scan read address ran past the stored count")
  `NSNS_ASSERT_NXT(a_query_scans, clk_i, rst_ni, accept && in_operation_i == nsns_pkg::OP_QUERY && count_i != '0, state_q == nsns_pkg::ST_SCAN, "query on a filled store did not start a scan")
  `NSNS_ASSERT_IMP(a_compare_in_scan, clk_i, rst_ni, status_i.hit || status_i.last_done, state_q == nsns_pkg::ST_SCAN, "compare stage active outside a scan")

endmodule

FILE: rtl/core/nsns_dpath.sv
// Datapath: point memory, bounding box, distance pipeline, best tracker, result register.
// Depends on nsns_pkg and nsns_ram.
module nsns_dpath #(
  parameter int unsigned MAX_POINTS = nsns_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = nsns_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  nsns_pkg::cmd_t                        cmd_i,
  output nsns_pkg::status_t                     status_o,
  input  logic [$clog2(MAX_POINTS+1)-1:0]       rd_addr_i,
  output logic [$clog2(MAX_POINTS+1)-1:0]       count_o,
  input  logic [nsns_pkg::TOL_W-1:0]            tol_i,
  input  logic                                  operation_i,
  input  logic signed [COORD_BITS-1:0]          x_coord_i,
  input  logic signed [COORD_BITS-1:0]          y_coord_i,
  input  logic signed [COORD_BITS-1:0]          z_coord_i,
  input  logic [nsns_pkg::IDENT_W-1:0]          point_ident_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [nsns_pkg::IDENT_W-1:0]          nearest_ident_o,
  output logic                                  within_tolerance_o,
  output logic                                  add_rejected_o,
  output logic [$clog2(MAX_POINTS+1)-1:0]       point_count_o,
  output logic signed [COORD_BITS-1:0]          box_min_x_o,
  output logic signed [COORD_BITS-1:0]          box_min_y_o,
  output logic signed [COORD_BITS-1:0]          box_min_z_o,
  output logic signed [COORD_BITS-1:0]          box_max_x_o,
  output logic signed [COORD_BITS-1:0]          box_max_y_o,
  output logic signed [COORD_BITS-1:0]          box_max_z_o
);

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned IW     = nsns_pkg::IDENT_W;
  localparam int unsigned TW     = nsns_pkg::TOL_W;
  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW     = $clog2(MAX_POINTS);
  localparam int unsigned WORD_W = 3 * CB + IW;
  localparam int unsigned SQ_W   = 2 * CB;
  localparam int unsigned SUM_W  = 2 * CB + 2;
  localparam int unsigned DIST_W = (SUM_W > 64) ? 64 : SUM_W;
  localparam int unsigned CMP_W  = (DIST_W > TW) ? DIST_W : TW;

  // ---------------- store, count and bounding box ----------------
  logic signed [CB-1:0] pt [3];
  logic signed [CB-1:0] box_min_q [3];
  logic signed [CB-1:0] box_max_q [3];
  logic [CNT_W-1:0]     count_q;
  logic                 full;
  logic                 do_add;
  logic [WORD_W-1:0]    wdata;
  logic [WORD_W-1:0]    rdata;

  assign pt[0]  = x_coord_i;
  assign pt[1]  = y_coord_i;
  assign pt[2]  = z_coord_i;
  assign full   = count_q == CNT_W'(MAX_POINTS);
  assign do_add = cmd_i.accept && operation_i == nsns_pkg::OP_ADD && !full;
  assign wdata  = {x_coord_i, y_coord_i, z_coord_i, point_ident_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int k = 0; k < 3; k++) begin
        box_min_q[k] <= '0;
        box_max_q[k] <= '0;
      end
    end else if (do_add) begin
      count_q <= count_q + CNT_W'(1);
      for (int k = 0; k < 3; k++) begin
        if (count_q == '0 || pt[k] < box_min_q[k]) begin
          box_min_q[k] <= pt[k];
        end
        if (count_q == '0 || pt[k] > box_max_q[k]) begin
          box_max_q[k] <= pt[k];
        end
      end
    end
  end

  assign count_o = count_q;

  nsns_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (do_add),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i[AW-1:0]),
    .rdata_o (rdata)
  );

  // ---------------- query point and per-beat flags ----------------
  logic signed [CB-1:0] qry_q [3];
  logic                 rej_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int k = 0; k < 3; k++) begin
        qry_q[k] <= pt[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rej_q <= 1'b0;
    end else if (cmd_i.accept) begin
      rej_q <= operation_i == nsns_pkg::OP_ADD && full;
    end
  end

  // ---------------- distance pipeline ----------------
  // Stage 0 is the RAM read, 1 the axis magnitudes, 2 the squares, 3 the sum.
  logic [3:0] vld_q, first_q, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      first_q <= '0;
      last_q  <= '0;
    end else if (cmd_i.flush) begin
      vld_q   <= '0;
      first_q <= '0;
      last_q  <= '0;
    end else begin
      vld_q   <= {vld_q[2:0], cmd_i.rd_en};
      first_q <= {first_q[2:0], cmd_i.rd_first};
      last_q  <= {last_q[2:0], cmd_i.rd_last};
    end
  end

  logic signed [CB-1:0] st_pt [3];
  logic signed [CB:0]   diff [3];
  logic signed [CB:0]   diff_neg [3];
  logic [CB-1:0]        mag_q [3];
  logic [SQ_W-1:0]      sq_q [3];
  logic [SUM_W-1:0]     sum;
  logic [DIST_W-1:0]    dist_q;
  logic [IW-1:0]        id1_q, id2_q, id3_q;

  assign st_pt[0] = rdata[3*CB+IW-1 -: CB];
  assign st_pt[1] = rdata[2*CB+IW-1 -: CB];
  assign st_pt[2] = rdata[CB+IW-1 -: CB];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]     = {st_pt[k][CB-1], st_pt[k]} - {qry_q[k][CB-1], qry_q[k]};
      diff_neg[k] = -diff[k];
    end
  end

  assign sum = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      mag_q[k] <= diff[k][CB] ? diff_neg[k][CB-1:0] : diff[k][CB-1:0];
      sq_q[k]  <= SQ_W'(mag_q[k]) * SQ_W'(mag_q[k]);
    end
    // saturate at the all-ones distance
    if (sum > SUM_W'({DIST_W{1'b1}})) begin
      dist_q <= '1;
    end else begin
      dist_q <= DIST_W'(sum);
    end
    id1_q <= rdata[IW-1:0];
    id2_q <= id1_q;
    id3_q <= id2_q;
  end

  // ---------------- compare and best tracking ----------------
  logic              tol_hit;
  logic [DIST_W-1:0] best_d_q;
  logic [IW-1:0]     best_id_q;
  logic              inside_q;

  assign tol_hit = vld_q[3] && (CMP_W'(dist_q) <= CMP_W'(tol_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_id_q <= '0;
      inside_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      best_id_q <= '0;
      inside_q  <= 1'b0;
    end else if (tol_hit) begin
      best_id_q <= id3_q;
      inside_q  <= 1'b1;
    end else if (vld_q[3] && (first_q[3] || dist_q < best_d_q)) begin
      best_id_q <= id3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[3] && (first_q[3] || dist_q < best_d_q)) begin
      best_d_q <= dist_q;
    end
  end

  assign status_o.hit       = tol_hit;
  assign status_o.last_done = vld_q[3] && last_q[3];
  assign status_o.out_free  = !out_valid_o || !out_stall_i;

  // ---------------- output register ----------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      nearest_ident_o    <= best_id_q;
      within_tolerance_o <= inside_q;
      add_rejected_o     <= rej_q;
      point_count_o      <= count_q;
      box_min_x_o        <= box_min_q[0];
      box_min_y_o        <= box_min_q[1];
      box_min_z_o        <= box_min_q[2];
      box_max_x_o        <= box_max_q[0];
      box_max_y_o        <= box_max_q[1];
      box_max_z_o        <= box_max_q[2];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/node_store_nearest_search.sv
// Point store with nearest-point search. An add beat is dropped, with
// add_rejected set, once MAX_POINTS points are stored. A query reads the
// stored points one per cycle through the single read port of the point
// memory and runs them through a four-stage distance pipeline, stopping
// early on the first point within tolerance_squared; an empty store answers
// without a scan. One beat is worked at a time; the next is taken while a
// finished result still waits in the output register. The memory needs no
// clearing after reset. tolerance_squared sits at byte address 0 of the APB
// port.
module node_store_nearest_search #(
  parameter int unsigned MAX_POINTS = nsns_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = nsns_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nsns_pkg::PADDR_W-1:0]        paddr,
  input  logic [nsns_pkg::PDATA_W-1:0]        pwdata,
  output logic [nsns_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic signed [COORD_BITS-1:0]        x_coord_i,
  input  logic signed [COORD_BITS-1:0]        y_coord_i,
  input  logic signed [COORD_BITS-1:0]        z_coord_i,
  input  logic [nsns_pkg::IDENT_W-1:0]        point_ident_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [nsns_pkg::IDENT_W-1:0]        nearest_ident_o,
  output logic                                within_tolerance_o,
  output logic                                add_rejected_o,
  output logic [$clog2(MAX_POINTS+1)-1:0]     point_count_o,
  output logic signed [COORD_BITS-1:0]        box_min_x_o,
  output logic signed [COORD_BITS-1:0]        box_min_y_o,
  output logic signed [COORD_BITS-1:0]        box_min_z_o,
  output logic signed [COORD_BITS-1:0]        box_max_x_o,
  output logic signed [COORD_BITS-1:0]        box_max_y_o,
  output logic signed [COORD_BITS-1:0]        box_max_z_o
);

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned TW    = nsns_pkg::TOL_W;
  localparam int unsigned PW    = nsns_pkg::PDATA_W;

  logic [TW-1:0]     tol_q;
  logic              tol_sel;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rd_addr;
  nsns_pkg::cmd_t    cmd;
  nsns_pkg::status_t status;

  assign tol_sel = paddr[3] == nsns_pkg::TOL_REG_IDX;
  assign pready  = 1'b1;
  assign prdata  = tol_sel ? PW'(tol_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (psel && penable && pwrite && pready && tol_sel) begin
      tol_q <= pwdata[TW-1:0];
    end
  end

  nsns_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_operation_i (operation_i),
    .count_i        (count),
    .status_i       (status),
    .cmd_o          (cmd),
    .rd_addr_o      (rd_addr)
  );

  nsns_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .rd_addr_i          (rd_addr),
    .count_o            (count),
    .tol_i              (tol_q),
    .operation_i        (operation_i),
    .x_coord_i          (x_coord_i),
    .y_coord_i          (y_coord_i),
    .z_coord_i          (z_coord_i),
    .point_ident_i      (point_ident_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .nearest_ident_o    (nearest_ident_o),
    .within_tolerance_o (within_tolerance_o),
    .add_rejected_o     (add_rejected_o),
    .point_count_o      (point_count_o),
    .box_min_x_o        (box_min_x_o),
    .box_min_y_o        (box_min_y_o),
    .box_min_z_o        (box_min_z_o),
    .box_max_x_o        (box_max_x_o),
    .box_max_y_o        (box_max_y_o),
    .box_max_z_o        (box_max_z_o)
  );

endmodule

FILE: tb/tb_node_store_nearest_search.sv
// Self-checking testbench for node_store_nearest_search: add and query beats
// are checked against an in-bench model of the point store and its bounding box.
// Depends on nsns_pkg and the node_store_nearest_search RTL only.
`timescale 1ns / 1ps

module tb_node_store_nearest_search;

  localparam int CW      = nsns_pkg::COORD_BITS_DEF;
  localparam int MAX_PTS = nsns_pkg::MAX_POINTS_DEF;
  localparam int CNT_W   = $clog2(MAX_PTS + 1);
  localparam int QUIET_LIMIT = 6000;
  localparam logic [nsns_pkg::PADDR_W-1:0] TOL_ADDR = {nsns_pkg::TOL_REG_IDX, 3'b000};
  // three full-span axes, squared and summed
  localparam logic [63:0] FULL_SPAN_SQ = 64'd12884508675;

  typedef struct packed {
    logic          op;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [15:0]   ident;
  } store_item_t;

  localparam int ITEM_W = $bits(store_item_t);

  typedef struct packed {
    logic [15:0]      ident;
    logic             hit;
    logic             rejected;
    logic [CNT_W-1:0] count;
    logic [CW-1:0]    min_x;
    logic [CW-1:0]    min_y;
    logic [CW-1:0]    min_z;
    logic [CW-1:0]    max_x;
    logic [CW-1:0]    max_y;
    logic [CW-1:0]    max_z;
  } store_answer_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [nsns_pkg::PADDR_W-1:0] paddr;
  logic [nsns_pkg::PDATA_W-1:0] pwdata, prdata;
  logic in_valid_i, in_stall_o, out_valid_o;
  logic out_stall_i = 1'b0;
  logic operation_i;
  logic signed [CW-1:0] x_coord_i, y_coord_i, z_coord_i;
  logic [15:0] point_ident_i, nearest_ident_o;
  logic within_tolerance_o, add_rejected_o;
  logic [CNT_W-1:0] point_count_o;
  logic signed [CW-1:0] box_min_x_o, box_min_y_o, box_min_z_o;
  logic signed [CW-1:0] box_max_x_o, box_max_y_o, box_max_z_o;

  // model of the store
  logic signed [CW-1:0] pt_x [MAX_PTS];
  logic signed [CW-1:0] pt_y [MAX_PTS];
  logic signed [CW-1:0] pt_z [MAX_PTS];
  logic [15:0]          pt_id [MAX_PTS];
  logic signed [CW-1:0] box_lo [3];
  logic signed [CW-1:0] box_hi [3];
  int                   pt_count = 0;
  logic [nsns_pkg::TOL_W-1:0] tol_sq = '0;

  store_answer_t answer_q [$];
  int          mismatches = 0;
  int          burst_left = 0;
  int          quiet_cycles = 0;
  bit          hold_request = 1'b0;
  int          hold_left = 0;
  int          mode_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  node_store_nearest_search dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .x_coord_i          (x_coord_i),
    .y_coord_i          (y_coord_i),
    .z_coord_i          (z_coord_i),
    .point_ident_i      (point_ident_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .nearest_ident_o    (nearest_ident_o),
    .within_tolerance_o (within_tolerance_o),
    .add_rejected_o     (add_rejected_o),
    .point_count_o      (point_count_o),
    .box_min_x_o        (box_min_x_o),
    .box_min_y_o        (box_min_y_o),
    .box_min_z_o        (box_min_z_o),
    .box_max_x_o        (box_max_x_o),
    .box_max_y_o        (box_max_y_o),
    .box_max_z_o        (box_max_z_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned gap_sq(logic signed [CW-1:0] a, logic signed [CW-1:0] b);
    longint diff;
    diff = longint'(a) - longint'(b);
    if (diff < 0) diff = -diff;
    return diff * diff;
  endfunction

  function automatic store_answer_t predict_store_answer(input store_item_t it);
    store_answer_t        ans;
    logic signed [CW-1:0] p [3];
    longint unsigned      d, best;
    int                   i, k;
    ans  = '0;
    best = 0;
    p[0] = it.x;
    p[1] = it.y;
    p[2] = it.z;
    if (it.op == nsns_pkg::OP_ADD) begin
      if (pt_count >= MAX_PTS) begin
        ans.rejected = 1'b1;
      end else begin
        for (k = 0; k < 3; k++) begin
          if (pt_count == 0 || p[k] < box_lo[k]) box_lo[k] = p[k];
          if (pt_count == 0 || p[k] > box_hi[k]) box_hi[k] = p[k];
        end
        pt_x[pt_count]  = p[0];
        pt_y[pt_count]  = p[1];
        pt_z[pt_count]  = p[2];
        pt_id[pt_count] = it.ident;
        pt_count++;
      end
    end else begin
      // first point within tolerance stops the walk, else strictly nearest wins
      for (i = 0; i < pt_count && !ans.hit; i++) begin
        d = gap_sq(pt_x[i], p[0]) + gap_sq(pt_y[i], p[1]) + gap_sq(pt_z[i], p[2]);
        if (d <= longint'(tol_sq)) begin
          ans.ident = pt_id[i];
          ans.hit   = 1'b1;
        end else if (i == 0 || d < best) begin
          ans.ident = pt_id[i];
          best      = d;
        end
      end
    end
    ans.count = pt_count[CNT_W-1:0];
    ans.min_x = box_lo[0];
    ans.min_y = box_lo[1];
    ans.min_z = box_lo[2];
    ans.max_x = box_hi[0];
    ans.max_y = box_hi[1];
    ans.max_z = box_hi[2];
    return ans;
  endfunction

  function automatic store_item_t mk_item(logic op, int x, int y, int z, int id);
    store_item_t it;
    it.op    = op;
    it.x     = x[CW-1:0];
    it.y     = y[CW-1:0];
    it.z     = z[CW-1:0];
    it.ident = id[15:0];
    return it;
  endfunction

  function automatic store_item_t rand_item();
    return ITEM_W'({$urandom, $urandom, $urandom});
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Result side: compare each beat with the oldest prediction.
  always @(posedge clk_i) begin
    store_answer_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (answer_q.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, ident %0h", $time, nearest_ident_o);
      end else begin
        want = answer_q.pop_front();
        check_field("nearest_ident", 64'(want.ident), 64'(nearest_ident_o));
        check_field("within_tolerance", 64'(want.hit), 64'(within_tolerance_o));
        check_field("add_rejected", 64'(want.rejected), 64'(add_rejected_o));
        check_field("point_count", 64'(want.count), 64'(point_count_o));
        check_field("box_min_x", 64'(want.min_x), 64'($unsigned(box_min_x_o)));
        check_field("box_min_y", 64'(want.min_y), 64'($unsigned(box_min_y_o)));
        check_field("box_min_z", 64'(want.min_z), 64'($unsigned(box_min_z_o)));
        check_field("box_max_x", 64'(want.max_x), 64'($unsigned(box_max_x_o)));
        check_field("box_max_y", 64'(want.max_y), 64'($unsigned(box_max_y_o)));
        check_field("box_max_z", 64'(want.max_z), 64'($unsigned(box_max_z_o)));
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = 400;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(8, 150);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= mode_left[0];
      endcase
    end
  end

  // Watchdog: long runs without any accepted beat end the run.
  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input store_item_t it);
    in_valid_i    <= 1'b1;
    operation_i   <= it.op;
    x_coord_i     <= it.x;
    y_coord_i     <= it.y;
    z_coord_i     <= it.z;
    point_ident_i <= it.ident;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    answer_q.insert(answer_q.size(), predict_store_answer(it));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(10, 30)) @(posedge clk_i);
      else repeat ($urandom_range(1, 4)) @(posedge clk_i);
      if ($urandom_range(0, 5) == 0) burst_left = $urandom_range(40, 80);
      else burst_left = $urandom_range(0, 12);
    end
  endtask

  // Drop valid and wait until every expected result is out.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TOL_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    tol_sq  = value[nsns_pkg::TOL_W-1:0];
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field("tolerance_squared readback", 64'(tol_sq),
                64'(prdata[nsns_pkg::TOL_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    write_tolerance(64'd0);
    send_item(mk_item(nsns_pkg::OP_QUERY, 0, 0, 0, 16'h5A5A));   // empty store
    send_item(mk_item(nsns_pkg::OP_ADD, -32768, 32767, 0, 16'hFFFF));
    send_item(mk_item(nsns_pkg::OP_ADD, 32767, -32768, -1, 16'h0000));
    send_item(mk_item(nsns_pkg::OP_ADD, 100, 0, 0, 16'h1111));
    send_item(mk_item(nsns_pkg::OP_ADD, -100, 0, 0, 16'h2222));
    send_item(mk_item(nsns_pkg::OP_QUERY, 0, 0, 0, 0));          // tie, earlier wins
    send_item(mk_item(nsns_pkg::OP_QUERY, -32768, 32767, 0, 0)); // exact hit
    send_item(mk_item(nsns_pkg::OP_QUERY, 32767, 32767, 32767, 0));
    send_item(mk_item(nsns_pkg::OP_QUERY, -32768, -32768, -32768, 16'hFFFF));
    send_item(mk_item(nsns_pkg::OP_ADD, 100, 0, 0, 16'h3333));   // duplicate point
    send_item(mk_item(nsns_pkg::OP_QUERY, 100, 0, 1, 0));
    settle_block();
    write_tolerance(64'd10000);                                  // boundary: d == tol
    send_item(mk_item(nsns_pkg::OP_QUERY, 0, 0, 0, 0));
    settle_block();
    write_tolerance(64'd9999);
    send_item(mk_item(nsns_pkg::OP_QUERY, 0, 0, 0, 0));
    settle_block();
    write_tolerance('1);
    send_item(mk_item(nsns_pkg::OP_QUERY, 32767, 32767, 32767, 0));
    settle_block();
    write_tolerance(FULL_SPAN_SQ);
    send_item(mk_item(nsns_pkg::OP_QUERY, 32767, -32768, 32767, 0));
    settle_block();
    // upper bits beyond the register width must be dropped
    write_tolerance(64'hFFFF_FFFC_0000_0000);
    send_item(mk_item(nsns_pkg::OP_QUERY, 1, 2, 3, 0));
    settle_block();
  endtask

  task automatic test_random_mix(input int n_items);
    store_item_t it;
    int          rnd, sel, pick;
    for (rnd = 0; rnd < 4; rnd++) begin
      case (rnd)
        0:       write_tolerance(64'($urandom_range(0, 3000)));
        1:       write_tolerance({$urandom, $urandom});
        2:       write_tolerance('1);
        default: write_tolerance(64'd0);
      endcase
      repeat (n_items / 4) begin
        it.op    = ($urandom_range(0, 99) < 45) ? nsns_pkg::OP_ADD : nsns_pkg::OP_QUERY;
        it.x     = CW'($urandom);
        it.y     = CW'($urandom);
        it.z     = CW'($urandom);
        it.ident = 16'($urandom);
        if (pt_count > 0) begin
          sel  = $urandom_range(0, pt_count - 1);
          pick = $urandom_range(0, 99);
          if (pick < 15) begin
            it.x = pt_x[sel];
            it.y = pt_y[sel];
            it.z = pt_z[sel];
          end else if (pick < 55) begin
            // land near a stored point so tolerance decisions are close
            it.x = CW'(pt_x[sel] + $urandom_range(0, 64) - 32);
            it.y = CW'(pt_y[sel] + $urandom_range(0, 64) - 32);
            it.z = CW'(pt_z[sel] + $urandom_range(0, 64) - 32);
          end
        end
        send_item(it);
      end
      settle_block();
    end
  endtask

  task automatic test_output_backlog();
    store_item_t it;
    hold_request = 1'b1;
    repeat (16) begin
      it       = rand_item();
      it.op    = 1'($urandom_range(0, 1));
      send_item(it);
    end
    settle_block();
  endtask

  task automatic test_long_walk();
    store_item_t it;
    write_tolerance(64'd0);
    // walk the whole store: match on the newest entry
    send_item(mk_item(nsns_pkg::OP_QUERY, pt_x[pt_count-1], pt_y[pt_count-1],
                      pt_z[pt_count-1], 0));
    send_item(mk_item(nsns_pkg::OP_QUERY, pt_x[0], pt_y[0], pt_z[0], 0));
    it    = rand_item();
    it.op = nsns_pkg::OP_QUERY;
    send_item(it);
    settle_block();
    write_tolerance({30'($urandom_range(0, 3)), $urandom});
    repeat (3) begin
      it    = rand_item();
      it.op = 1'($urandom_range(0, 1));
      send_item(it);
    end
    settle_block();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid_i    <= 1'b0;
    operation_i   <= nsns_pkg::OP_ADD;
    x_coord_i     <= '0;
    y_coord_i     <= '0;
    z_coord_i     <= '0;
    point_ident_i <= '0;
    box_lo        = '{default: '0};
    box_hi        = '{default: '0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_mix(540);
    test_output_backlog();
    test_long_walk();

    settle_block();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
